/* design/rsi_pkg.sv */
// Shared types, constants and character decode for the radix string parser.
package rsi_pkg;

  localparam int CHAR_W  = 16;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int VALUE_W = 64;
  localparam int ERR_W   = 2;
  // magnitude times radix plus digit needs this many bits
  localparam int PROD_W  = VALUE_W + RADIX_W;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIGIT     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LONE_SIGN = 2'd3;

  localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 16'h002D;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // largest positive magnitude; a negative result may reach one more
  localparam logic [VALUE_W-1:0] MAG_POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               digit_ok;
    logic               is_minus;
    logic               last;
  } dig_t;

  function automatic dig_t decode_char(logic [CHAR_W-1:0] c, logic [RADIX_W-1:0] r);
    dig_t               res;
    logic [DIGIT_W-1:0] d;
    logic               is_dig;
    d      = '0;
    is_dig = 1'b0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      d      = DIGIT_W'(c - 16'h0030);
      is_dig = 1'b1;
    end else if (c >= 16'h0061 && c <= 16'h007A) begin
      d      = DIGIT_W'(c - 16'h0061) + 6'd10;
      is_dig = 1'b1;
    end else if (c >= 16'h0041 && c <= 16'h005A) begin
      d      = DIGIT_W'(c - 16'h0041) + 6'd10;
      is_dig = 1'b1;
    end
    res.digit    = d;
    res.digit_ok = is_dig && (r >= RADIX_MIN) && (r <= RADIX_MAX) && (d < r);
    res.is_minus = (c == MINUS_CHAR);
    res.last     = 1'b0;
    return res;
  endfunction

endpackage

/* design/rsi_decode.sv */
// Input register: takes a character request and holds its decoded digit.
module rsi_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rsi_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  input  logic [rsi_pkg::RADIX_W-1:0]   radix,
  output logic                          dig_valid,
  output rsi_pkg::dig_t                 dig,
  input  logic                          dig_take
);
  import rsi_pkg::*;

  dig_t dig_next;

  always_comb begin
    dig_next      = decode_char(char_code, radix);
    dig_next.last = last_char;
  end

  // the held request can be replaced in the same cycle it moves on
  assign in_stall = dig_valid && !dig_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      dig_valid <= 1'b1;
    end else if (dig_take) begin
      dig_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      dig <= dig_next;
    end
  end

endmodule

/* design/rsi_accum.sv */
// String state, multiply-accumulate with bound check, and the result register.
module rsi_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rsi_pkg::RADIX_W-1:0]   radix,
  input  logic                          dig_valid,
  input  rsi_pkg::dig_t                 dig,
  output logic                          dig_take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [rsi_pkg::VALUE_W-1:0] value,
  output logic [rsi_pkg::ERR_W-1:0]     error_code
);
  import rsi_pkg::*;

  // magnitude parsed so far; reaches 2^63 only for a negative string
  logic [VALUE_W-1:0] mag, mag_next;
  logic               at_start, at_start_next;
  logic               is_negative, is_negative_next;
  logic               seen_digit, seen_digit_next;
  logic [ERR_W-1:0]   pend, pend_next;
  logic [PROD_W-1:0]  prod, limit;
  logic [ERR_W-1:0]   res_err;
  logic [VALUE_W-1:0] res_val;

  assign dig_take = dig_valid && (!dig.last || !out_valid || !out_stall);

  always_comb begin
    prod  = PROD_W'(mag) * PROD_W'(radix) + PROD_W'(dig.digit);
    limit = PROD_W'(MAG_POS_MAX) + PROD_W'(is_negative);

    mag_next         = mag;
    at_start_next    = 1'b0;
    is_negative_next = is_negative;
    seen_digit_next  = seen_digit;
    pend_next        = pend;

    if (at_start && dig.is_minus) begin
      is_negative_next = 1'b1;
    end else if (pend == ERR_NONE) begin
      if (!dig.digit_ok) begin
        pend_next = ERR_DIGIT;
      end else if (prod > limit) begin
        pend_next = ERR_OVERFLOW;
      end else begin
        mag_next        = prod[VALUE_W-1:0];
        seen_digit_next = 1'b1;
      end
    end

    res_err = pend_next;
    if (res_err == ERR_NONE && !seen_digit_next) begin
      res_err = ERR_LONE_SIGN;
    end
    if (res_err != ERR_NONE) begin
      res_val = '0;
    end else if (is_negative_next) begin
      res_val = VALUE_W'(-mag_next);
    end else begin
      res_val = mag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag         <= '0;
      at_start    <= 1'b1;
      is_negative <= 1'b0;
      seen_digit  <= 1'b0;
      pend        <= ERR_NONE;
    end else if (dig_take) begin
      if (dig.last) begin
        mag         <= '0;
        at_start    <= 1'b1;
        is_negative <= 1'b0;
        seen_digit  <= 1'b0;
        pend        <= ERR_NONE;
      end else begin
        mag         <= mag_next;
        at_start    <= at_start_next;
        is_negative <= is_negative_next;
        seen_digit  <= seen_digit_next;
        pend        <= pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dig_take && dig.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_take && dig.last) begin
      value      <= $signed(res_val);
      error_code <= res_err;
    end
  end

endmodule

/* design/radix_string_to_int64.sv */
// Top level: radix register, input decode stage and accumulate/result stage.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   in       | in_valid / in_stall   | char_code[15:0], last_char
//   out      | out_valid / out_stall | value[63:0] signed, error_code[1:0]
//   config   | cfg_wr_en             | cfg_wr_data[5:0] (radix)
//
// One character per cycle unless a last character waits behind a stalled result. The limit
// is the loop through the magnitude register: multiply by radix, add digit, compare against
// the bound. A result is registered by the edge at which the accumulate stage takes its last character.
// Reset clears all string state, empties both stages and sets radix to 10.
// A stalled result holds; characters keep flowing until a last character
// waits behind it.
module radix_string_to_int64 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rsi_pkg::RADIX_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rsi_pkg::CHAR_W-1:0]         char_code,
  input  logic                               last_char,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rsi_pkg::VALUE_W-1:0] value,
  output logic [rsi_pkg::ERR_W-1:0]          error_code
);
  import rsi_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic               dig_valid;
  logic               dig_take;
  dig_t               dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  rsi_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .radix     (radix),
    .dig_valid (dig_valid),
    .dig       (dig),
    .dig_take  (dig_take)
  );

  rsi_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .radix      (radix),
    .dig_valid  (dig_valid),
    .dig        (dig),
    .dig_take   (dig_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .error_code (error_code)
  );

endmodule

/* design/rsi_checker.sv */
// Port-level checks for the radix string parser, bound to the top level.
module rsi_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [rsi_pkg::CHAR_W-1:0]         char_code,
  input  logic                               last_char,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [rsi_pkg::VALUE_W-1:0] value,
  input  logic [rsi_pkg::ERR_W-1:0]          error_code
);
  import rsi_pkg::*;

  // a stalled character request keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_code) && $stable(last_char))
    else $error("character request changed while stalled");

  // a result held by the receiver stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(error_code))
    else $error("result changed while stalled");

  // any error reports a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> value == '0)
    else $error("nonzero value with error");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind radix_string_to_int64 rsi_checker u_rsi_checker (.*);

/* test/tb_radix_string_to_int64.sv */
// Testbench for radix_string_to_int64: random and directed strings checked against a parse model.
module tb_radix_string_to_int64;
  import rsi_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_CHARS  = 85;

  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 16'h002B;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 16'h0030;
  localparam logic [CHAR_W-1:0] LOWER_A    = 16'h0061;
  localparam logic [CHAR_W-1:0] UPPER_A    = 16'h0041;
  localparam logic [CHAR_W-1:0] ARABIC_0   = 16'h0660;
  localparam logic [CHAR_W-1:0] WIDE_0     = 16'hFF10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [ERR_W-1:0]          err;
  } parse_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]          cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CHAR_W-1:0]           char_code = '0;
  logic                        last_char = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [VALUE_W-1:0]   value;
  logic [ERR_W-1:0]            error_code;

  radix_string_to_int64 u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .error_code (error_code)
  );

  always #CLK_HALF clk = ~clk;

  char_req_t       char_q[$];
  parse_result_t   expected_results[$];
  logic [CHAR_W-1:0] str_q[$];
  int              chars_queued = 0;
  int              chars_taken = 0;
  int              fail_cnt = 0;
  int              cycle_cnt = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;

  // parse model state
  logic [RADIX_W-1:0]        model_radix = RADIX_RESET;
  logic signed [VALUE_W-1:0] neg_acc = '0;
  logic                      at_start = 1'b1;
  logic                      is_neg = 1'b0;
  logic                      seen_digit = 1'b0;
  logic [ERR_W-1:0]          first_err = ERR_NONE;

  function automatic int char_digit(logic [CHAR_W-1:0] c, logic [RADIX_W-1:0] r);
    int d;
    if (r < RADIX_MIN || r > RADIX_MAX) return -1;
    if (c >= 16'h0030 && c <= 16'h0039) d = int'(c - 16'h0030);
    else if (c >= 16'h0061 && c <= 16'h007A) d = int'(c - 16'h0061) + 10;
    else if (c >= 16'h0041 && c <= 16'h005A) d = int'(c - 16'h0041) + 10;
    else return -1;
    return (d < int'(r)) ? d : -1;
  endfunction

  task automatic accumulate_digit(input logic [CHAR_W-1:0] c);
    int d;
    logic signed [VALUE_W-1:0] lim, mult_min, prod, rad_s, dig_s;
    d = char_digit(c, model_radix);
    if (d < 0) begin
      first_err = ERR_DIGIT;
      return;
    end
    rad_s = {{(VALUE_W-RADIX_W){1'b0}}, model_radix};
    dig_s = VALUE_W'(d);
    // negative accumulation: positive numbers are bounded at minus the max
    lim = is_neg ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
    mult_min = lim / rad_s;
    if (neg_acc < mult_min) begin
      first_err = ERR_OVERFLOW;
      return;
    end
    prod = neg_acc * rad_s;
    if (prod < lim + dig_s) begin
      first_err = ERR_OVERFLOW;
      return;
    end
    neg_acc = prod - dig_s;
    seen_digit = 1'b1;
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
    parse_result_t res;
    if (at_start && c == MINUS_CHAR) is_neg = 1'b1;
    else if (first_err == ERR_NONE) accumulate_digit(c);
    at_start = 1'b0;
    if (!last) return;
    res.err = first_err;
    if (res.err == ERR_NONE && !seen_digit) res.err = ERR_LONE_SIGN;
    if (res.err != ERR_NONE) res.value = '0;
    else res.value = is_neg ? neg_acc : -neg_acc;
    expected_results.push_back(res);
    neg_acc = '0;
    at_start = 1'b1;
    is_neg = 1'b0;
    seen_digit = 1'b0;
    first_err = ERR_NONE;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(int d, bit upper);
    if (d < 10) return ZERO_CHAR + CHAR_W'(d);
    return (upper ? UPPER_A : LOWER_A) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] odd_char();
    case ($urandom_range(9))
      0: return PLUS_CHAR;
      1: return MINUS_CHAR;
      2: return 16'h002F;                              // just below '0'
      3: return 16'h003A;                              // just above '9'
      4: return 16'h0040;                              // just below 'A'
      5: return 16'h005B;                              // just above 'Z'
      6: return 16'h0060;                              // just below 'a'
      7: return 16'h007B;                              // just above 'z'
      8: return ($urandom_range(1) ? ARABIC_0 : WIDE_0) + CHAR_W'($urandom_range(9));
      default: return CHAR_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic flush_string();
    char_req_t req;
    foreach (str_q[i]) begin
      req.code = str_q[i];
      req.last = (i == str_q.size() - 1);
      char_q.push_back(req);
    end
    chars_queued += str_q.size();
    str_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(CHAR_W'(s[i]));
    flush_string();
  endtask

  task automatic add_magnitude(input logic [VALUE_W-1:0] mag, input int r);
    logic [CHAR_W-1:0] rev[$];
    logic [VALUE_W-1:0] rr;
    rr = VALUE_W'(r);
    do begin
      rev.push_front(digit_char(int'(mag % rr), 1'($urandom_range(1))));
      mag = mag / rr;
    end while (mag != 0);
    foreach (rev[i]) str_q.push_back(rev[i]);
  endtask

  task automatic gen_string();
    int kind, len, r_eff, pos;
    logic [VALUE_W-1:0] mag;
    kind = $urandom_range(99);
    r_eff = (model_radix >= RADIX_MIN && model_radix <= RADIX_MAX) ? int'(model_radix) : 36;
    if (kind < 45) begin
      if ($urandom_range(1)) str_q.push_back(MINUS_CHAR);
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 1) : $urandom_range(12, 1);
      repeat (len) str_q.push_back(digit_char($urandom_range(r_eff - 1), 1'($urandom_range(1))));
    end else if (kind < 65) begin
      // values around the signed 64-bit limits
      case ($urandom_range(5))
        0: mag = MAG_POS_MAX;
        1: mag = MAG_POS_MAX + 1;
        2: mag = MAG_POS_MAX + 2;
        3: mag = '1;
        4: mag = {$urandom, $urandom};
        default: mag = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      if ($urandom_range(1)) str_q.push_back(MINUS_CHAR);
      add_magnitude(mag, r_eff);
      if ($urandom_range(9) == 0) str_q.push_back(digit_char($urandom_range(r_eff - 1), 1'b0));
    end else if (kind < 72) begin
      str_q.push_back(MINUS_CHAR);
      if ($urandom_range(1)) str_q.push_back(MINUS_CHAR);
      if ($urandom_range(1)) str_q.push_back(digit_char($urandom_range(r_eff - 1), 1'b1));
    end else if (kind < 90) begin
      len = $urandom_range(8, 1);
      repeat (len) str_q.push_back(digit_char($urandom_range(r_eff - 1), 1'($urandom_range(1))));
      pos = $urandom_range(len - 1);
      str_q[pos] = odd_char();
    end else begin
      repeat ($urandom_range(5, 1)) str_q.push_back(CHAR_W'($urandom_range(16'hFFFF)));
    end
    flush_string();
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_radix = r;
  endtask

  task automatic wait_idle();
    while (chars_taken != chars_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // character driver: a stalled request holds its payload
  char_req_t next_req;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(char_code, last_char);
        chars_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = char_q.pop_front();
          in_valid  <= 1'b1;
          char_code <= next_req.code;
          last_char <= next_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  parse_result_t exp_r;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: value %0d, error_code %0d", value, error_code);
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          if (value !== exp_r.value) begin
            $error("value: expected %0d, got %0d", $signed(exp_r.value), value);
            fail_cnt++;
          end
          if (error_code !== exp_r.err) begin
            $error("error_code: expected %0d, got %0d", exp_r.err, error_code);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] radix_plan [12];
    int phase_start;
    radix_plan = '{6'd10, 6'd36, 6'd2, 6'd16, 6'd8, 6'd0, 6'd1, 6'd37, 6'd63, 6'd3,
                   6'd10, 6'd35};
    radix_plan[10] = RADIX_W'($urandom_range(36, 2));
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed strings at the reset radix
    push_text("-");          // lone sign
    push_text("+7");         // plus is never a sign
    push_text("4-");         // minus after the first character
    push_text("-0");
    push_text("Z");          // letter above radix ten
    str_q.push_back(16'hFFFF);
    flush_string();
    str_q.push_back(16'h0000);
    flush_string();
    str_q.push_back(MINUS_CHAR);
    str_q.push_back(ARABIC_0);   // non-ASCII digit, then a good digit: first error holds
    str_q.push_back(ZERO_CHAR + CHAR_W'(5));
    flush_string();
    push_text("9");
    wait_idle();
    write_radix(RADIX_MAX);
    push_text("zZ");
    push_text("-Az");
    wait_idle();
    write_radix(6'd0);       // no digit is valid outside two..thirty-six
    push_text("0");
    wait_idle();
    write_radix(RADIX_MIN);
    push_text("10");
    push_text("2");
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      write_radix(radix_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      phase_start = chars_queued;
      while (chars_queued - phase_start < PHASE_CHARS) gen_string();
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/rsi_pkg.sv
design/rsi_decode.sv
design/rsi_accum.sv
design/radix_string_to_int64.sv
design/rsi_checker.sv
test/tb_radix_string_to_int64.sv
